>>> rtl/core/srab_pkg.sv
package srab_pkg;

    // Result kinds
    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_TX    = 2'd2;
    localparam logic [1:0] KIND_CAL   = 2'd3;

    // Register indexes
    localparam logic [1:0] REG_BANK_A = 2'd0;
    localparam logic [1:0] REG_BANK_B = 2'd1;
    localparam logic [1:0] REG_BANK_C = 2'd2;
    localparam logic [1:0] REG_BANK_D = 2'd3;

    // Bank base reset values
    localparam logic [31:0] BANK_A_RST = 32'h4001_0000;
    localparam logic [31:0] BANK_B_RST = 32'h4000_0000;
    localparam logic [31:0] BANK_C_RST = 32'h4005_7000;
    localparam logic [31:0] BANK_D_RST = 32'h4007_5000;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] d;
    } bank_bases_t;

    // Group of result beats caused by one input beat
    typedef struct packed {
        logic [1:0]  kind;      // kind of the first beat; KIND_TX for a byte burst
        logic [1:0]  last_idx;  // index of the final beat
        logic [31:0] addr;
        logic [31:0] data;      // write data, or read data to transmit
    } bundle_t;

endpackage

>>> rtl/core/srab_cfg_regs.sv
module srab_cfg_regs
    import srab_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output bank_bases_t bases
);

    bank_bases_t bases_reg;
    logic        wr_en;
    logic [1:0]  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];
    assign bases   = bases_reg;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bases_reg.a <= BANK_A_RST;
            bases_reg.b <= BANK_B_RST;
            bases_reg.c <= BANK_C_RST;
            bases_reg.d <= BANK_D_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                REG_BANK_A: bases_reg.a <= pwdata;
                REG_BANK_B: bases_reg.b <= pwdata;
                REG_BANK_C: bases_reg.c <= pwdata;
                REG_BANK_D: bases_reg.d <= pwdata;
                default:    bases_reg.a <= bases_reg.a;
            endcase
        end
    end

    // Read mux
    always_comb begin
        unique case (reg_idx)
            REG_BANK_A: prdata = bases_reg.a;
            REG_BANK_B: prdata = bases_reg.b;
            REG_BANK_C: prdata = bases_reg.c;
            REG_BANK_D: prdata = bases_reg.d;
            default:    prdata = 32'd0;
        endcase
    end

endmodule

>>> rtl/core/srab_parser.sv
module srab_parser
    import srab_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_accept,
    input  logic        in_cmd,
    input  logic [7:0]  in_byte,
    input  logic [31:0] in_rdata,
    input  bank_bases_t bases,
    output logic        bundle_load,
    output bundle_t     bundle
);

    typedef enum logic [2:0] {
        PH_HEAD1 = 3'd0,
        PH_HEAD2 = 3'd1,
        PH_CMD   = 3'd2,
        PH_ADDR  = 3'd3,
        PH_DATA  = 3'd4,
        PH_WAIT  = 3'd5
    } phase_t;

    localparam logic [7:0]  HDR1     = 8'h9F;
    localparam logic [7:0]  HDR2     = 8'h8F;
    localparam logic [15:0] CMD_A_RD2 = 16'h0001;
    localparam logic [15:0] CMD_A_WR2 = 16'h0002;
    localparam logic [15:0] CMD_A_RD4 = 16'h0004;
    localparam logic [15:0] CMD_A_WR4 = 16'h0005;
    localparam logic [15:0] CMD_B_WR  = 16'h0010;
    localparam logic [15:0] CMD_B_RD  = 16'h0011;
    localparam logic [15:0] CMD_C_WR  = 16'h001E;
    localparam logic [15:0] CMD_C_RD  = 16'h001F;
    localparam logic [15:0] CMD_D_WR  = 16'h0020;
    localparam logic [15:0] CMD_D_RD  = 16'h0021;
    localparam logic [15:0] CAL_OFFSET = 16'h0004;

    phase_t      phase_reg,   phase_next;
    logic [1:0]  count_reg,   count_next;
    logic [15:0] command_reg, command_next;
    logic [15:0] offset_reg,  offset_next;
    logic [31:0] payload_reg, payload_next;

    logic [2:0]  pay_len;
    logic        cmd_is_read;
    logic [31:0] bank_sel;
    logic [31:0] bus_addr;
    logic [31:0] pay_acc;
    logic [31:0] wr_data;
    logic [2:0]  count_inc;
    logic        cal_req;

    // Command decode
    always_comb begin
        case (command_reg)
            CMD_A_RD2, CMD_A_WR2: pay_len = 3'd2;
            CMD_A_RD4, CMD_A_WR4, CMD_B_WR, CMD_B_RD,
            CMD_C_WR, CMD_C_RD, CMD_D_WR, CMD_D_RD: pay_len = 3'd4;
            default: pay_len = 3'd0;
        endcase
        case (command_reg)
            CMD_B_WR, CMD_B_RD: bank_sel = bases.b;
            CMD_C_WR, CMD_C_RD: bank_sel = bases.c;
            CMD_D_WR, CMD_D_RD: bank_sel = bases.d;
            default:            bank_sel = bases.a;
        endcase
        cmd_is_read = (command_reg == CMD_A_RD2) || (command_reg == CMD_A_RD4) ||
                      (command_reg == CMD_B_RD)  || (command_reg == CMD_C_RD)  ||
                      (command_reg == CMD_D_RD);
    end

    // Address, payload assembly
    assign bus_addr  = bank_sel + {16'd0, offset_reg};
    assign pay_acc   = payload_reg | ({24'd0, in_byte} << {count_reg, 3'b000});
    assign count_inc = {1'b0, count_reg} + 3'd1;
    assign wr_data   = (command_reg == CMD_A_WR2) ? {16'd0, pay_acc[15:0]} : pay_acc;
    assign cal_req   = (command_reg == CMD_D_WR) && (offset_reg == CAL_OFFSET) &&
                       (wr_data == 32'd1);

    // Frame parser next state
    always_comb begin
        phase_next   = phase_reg;
        count_next   = count_reg;
        command_next = command_reg;
        offset_next  = offset_reg;
        payload_next = payload_reg;
        bundle_load  = 1'b0;
        bundle       = '0;
        if (in_accept) begin
            if (in_cmd) begin
                // Read data return, sent out as a byte burst
                if (phase_reg == PH_WAIT) begin
                    bundle_load     = 1'b1;
                    bundle.kind     = KIND_TX;
                    bundle.last_idx = (command_reg == CMD_A_RD2) ? 2'd1 : 2'd3;
                    bundle.data     = in_rdata;
                    phase_next      = PH_HEAD1;
                    count_next      = 2'd0;
                end
            end else begin
                case (phase_reg)
                    PH_HEAD2: begin
                        phase_next = (in_byte == HDR2) ? PH_CMD : PH_HEAD1;
                        count_next = 2'd0;
                    end
                    PH_CMD: begin
                        if (count_reg == 2'd0) begin
                            command_next = {8'd0, in_byte};
                            count_next   = 2'd1;
                        end else begin
                            command_next = {in_byte, command_reg[7:0]};
                            count_next   = 2'd0;
                            phase_next   = PH_ADDR;
                        end
                    end
                    PH_ADDR: begin
                        if (count_reg == 2'd0) begin
                            offset_next = {8'd0, in_byte};
                            count_next  = 2'd1;
                        end else begin
                            offset_next  = {in_byte, offset_reg[7:0]};
                            count_next   = 2'd0;
                            payload_next = 32'd0;
                            phase_next   = (pay_len != 3'd0) ? PH_DATA : PH_HEAD1;
                        end
                    end
                    PH_DATA: begin
                        payload_next = pay_acc;
                        if (count_inc < pay_len) begin
                            count_next = count_inc[1:0];
                        end else begin
                            count_next  = 2'd0;
                            bundle_load = 1'b1;
                            bundle.addr = bus_addr;
                            if (cmd_is_read) begin
                                bundle.kind = KIND_READ;
                                phase_next  = PH_WAIT;
                            end else begin
                                payload_next    = wr_data;
                                bundle.kind     = KIND_WRITE;
                                bundle.data     = wr_data;
                                bundle.last_idx = cal_req ? 2'd1 : 2'd0;
                                phase_next      = PH_HEAD1;
                            end
                        end
                    end
                    PH_WAIT: begin
                        // bytes dropped while a read is outstanding
                    end
                    default: begin
                        count_next = 2'd0;
                        phase_next = (in_byte == HDR1) ? PH_HEAD2 : PH_HEAD1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_HEAD1;
            count_reg   <= 2'd0;
            command_reg <= 16'd0;
            offset_reg  <= 16'd0;
            payload_reg <= 32'd0;
        end else begin
            phase_reg   <= phase_next;
            count_reg   <= count_next;
            command_reg <= command_next;
            offset_reg  <= offset_next;
            payload_reg <= payload_next;
        end
    end

endmodule

>>> rtl/core/srab_emitter.sv
module srab_emitter
    import srab_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        bundle_load,
    input  bundle_t     bundle,
    output logic        load_ready,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,
    output logic [1:0]  m_tuser,
    output logic        m_tlast
);

    logic       valid_reg, valid_next;
    logic [1:0] idx_reg,   idx_next;
    bundle_t    bundle_reg;
    logic       is_last;
    logic [31:0] out_addr;
    logic [31:0] out_wdata;
    logic [7:0]  out_tx;
    logic [1:0]  out_kind;

    assign is_last    = (idx_reg == bundle_reg.last_idx);
    assign load_ready = !valid_reg || (m_tready && is_last);

    // Beat selection from the held group
    always_comb begin
        out_addr  = 32'd0;
        out_wdata = 32'd0;
        out_tx    = 8'd0;
        if (bundle_reg.kind == KIND_TX) begin
            out_kind = KIND_TX;
            out_tx   = bundle_reg.data[{idx_reg, 3'b000} +: 8];
        end else if (idx_reg == 2'd0) begin
            out_kind = bundle_reg.kind;
            out_addr = bundle_reg.addr;
            if (bundle_reg.kind == KIND_WRITE) begin
                out_wdata = bundle_reg.data;
            end
        end else begin
            out_kind = KIND_CAL;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {out_tx, out_wdata, out_addr};
    assign m_tuser  = out_kind;
    assign m_tlast  = is_last;

    // Beat sequencing
    always_comb begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (bundle_load && load_ready) begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end else if (valid_reg && m_tready) begin
            if (is_last) begin
                valid_next = 1'b0;
            end else begin
                idx_next = idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (bundle_load && load_ready) begin
            bundle_reg <= bundle;
        end
    end

endmodule

>>> rtl/core/serial_register_access_bridge_unit.sv
// Serial register access bridge.
// Slave stream: one beat is a received serial byte (tuser 0) or the data of a
// bus read coming back (tuser 1). Frames 9F 8F, command, offset, payload are
// parsed from the bytes; each completed frame gives one bus write beat
// (kind 0), a write plus a calibration request (kind 3), or a read request
// (kind 1). The returned read data goes out as 2 or 4 transmit-byte beats
// (kind 2), low byte first. tlast marks the final result of one input beat.
// Latency: results of a beat accepted at one edge are on m_* from the next
// cycle on. Throughput: one input beat per cycle while each beat causes at most
// one result; a beat causing more than one result keeps s_tready low while its
// result group drains through the single output stage.
// When m_tready is low the result is held and s_tready drops once the output
// stage is full; beats causing no result are still taken while it is free.
// Reset clears the parser to wait for a header and loads the bank bases with
// their default values. Bank bases are written through the APB port at
// byte addresses 0, 4, 8 and 12.
module serial_register_access_bridge_unit
    import srab_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // APB register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] rx_byte, [39:8] read_data
    input  logic        s_tuser,   // [0] cmd
    // Result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [31:0] bus_address, [63:32] write_data, [71:64] tx_byte
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast
);

    bank_bases_t bases;
    bundle_t     bundle;
    logic        bundle_load;
    logic        load_ready;
    logic        in_accept;

    assign s_tready  = load_ready;
    assign in_accept = s_tvalid && s_tready;

    srab_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .bases   (bases)
    );

    srab_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_accept   (in_accept),
        .in_cmd      (s_tuser),
        .in_byte     (s_tdata[7:0]),
        .in_rdata    (s_tdata[39:8]),
        .bases       (bases),
        .bundle_load (bundle_load),
        .bundle      (bundle)
    );

    srab_emitter u_emitter (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .bundle_load (bundle_load),
        .bundle      (bundle),
        .load_ready  (load_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

endmodule

>>> tb/bridge_checker.sv
package srab_tb_pkg;

    // Frame header bytes
    localparam logic [7:0] SYNC1 = 8'h9F;
    localparam logic [7:0] SYNC2 = 8'h8F;

    // Frame commands
    localparam logic [15:0] CMD_RD16   = 16'h0001;
    localparam logic [15:0] CMD_WR16   = 16'h0002;
    localparam logic [15:0] CMD_RD32_A = 16'h0004;
    localparam logic [15:0] CMD_WR32_A = 16'h0005;
    localparam logic [15:0] CMD_WR_B   = 16'h0010;
    localparam logic [15:0] CMD_RD_B   = 16'h0011;
    localparam logic [15:0] CMD_WR_C   = 16'h001E;
    localparam logic [15:0] CMD_RD_C   = 16'h001F;
    localparam logic [15:0] CMD_WR_D   = 16'h0020;
    localparam logic [15:0] CMD_RD_D   = 16'h0021;

    // Bank D write that also asks for clock calibration
    localparam logic [15:0] CAL_OFFSET = 16'h0004;
    localparam logic [31:0] CAL_VALUE  = 32'h0000_0001;

    // Input beat source (tuser)
    localparam logic SRC_RX    = 1'b0;
    localparam logic SRC_RDATA = 1'b1;

    function automatic int unsigned payload_bytes(input logic [15:0] c);
        case (c)
            CMD_RD16, CMD_WR16: return 2;
            CMD_RD32_A, CMD_WR32_A, CMD_WR_B, CMD_RD_B,
            CMD_WR_C, CMD_RD_C, CMD_WR_D, CMD_RD_D: return 4;
            default: return 0;
        endcase
    endfunction

    function automatic logic is_read_cmd(input logic [15:0] c);
        return c == CMD_RD16 || c == CMD_RD32_A || c == CMD_RD_B ||
               c == CMD_RD_C || c == CMD_RD_D;
    endfunction

    // Enumerates the ten valid commands
    function automatic logic [15:0] known_cmd(input int unsigned i);
        case (i)
            0: return CMD_RD16;
            1: return CMD_WR16;
            2: return CMD_RD32_A;
            3: return CMD_WR32_A;
            4: return CMD_WR_B;
            5: return CMD_RD_B;
            6: return CMD_WR_C;
            7: return CMD_RD_C;
            8: return CMD_WR_D;
            default: return CMD_RD_D;
        endcase
    endfunction

endpackage

module bridge_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,   // [7:0] rx_byte, [39:8] read_data
    input  logic        s_tuser,   // [0] cmd
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,   // [31:0] bus_address, [63:32] write_data, [71:64] tx_byte
    input  logic [1:0]  m_tuser,   // [1:0] kind
    input  logic        m_tlast,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import srab_pkg::*;
    import srab_tb_pkg::*;

    typedef enum logic [2:0] {
        WAIT_SYNC1 = 3'd0,
        WAIT_SYNC2 = 3'd1,
        GET_CMD    = 3'd2,
        GET_OFS    = 3'd3,
        GET_PAY    = 3'd4,
        READ_OUT   = 3'd5
    } frame_state_e;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] addr;
        logic [31:0] wdata;
        logic [7:0]  txb;
        logic        last;
    } bus_result_t;

    bus_result_t  outstanding[$];
    logic [31:0]  base_reg [4];
    frame_state_e fstate;
    logic [2:0]   field_cnt;
    logic [15:0]  cmd_word;
    logic [15:0]  ofs_word;
    logic [31:0]  pay_word;
    int           mismatches = 0;

    initial begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic void queue_result(input logic [1:0] kind, input logic [31:0] addr,
                                         input logic [31:0] wdata, input logic [7:0] txb,
                                         input logic last);
        bus_result_t r;
        r.kind  = kind;
        r.addr  = addr;
        r.wdata = wdata;
        r.txb   = txb;
        r.last  = last;
        outstanding.push_back(r);
    endfunction

    function automatic void flag(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("%s", msg);
    endfunction

    function automatic string show(input bus_result_t r);
        return $sformatf("kind %0d addr %h wdata %h tx %h last %b",
                         r.kind, r.addr, r.wdata, r.txb, r.last);
    endfunction

    function automatic logic [31:0] bank_of(input logic [15:0] c);
        case (c)
            CMD_WR_B, CMD_RD_B: return base_reg[REG_BANK_B];
            CMD_WR_C, CMD_RD_C: return base_reg[REG_BANK_C];
            CMD_WR_D, CMD_RD_D: return base_reg[REG_BANK_D];
            default:            return base_reg[REG_BANK_A];
        endcase
    endfunction

    // Advance the frame parser by one input beat, queueing what it should emit
    function automatic void parse_rx_beat(input logic src, input logic [7:0] b,
                                          input logic [31:0] rd);
        logic [31:0] target;
        int unsigned n;
        if (src == SRC_RDATA) begin
            // read data only matters while a read is outstanding
            if (fstate == READ_OUT) begin
                n = (cmd_word == CMD_RD16) ? 2 : 4;
                for (int k = 0; k < n; k++)
                    queue_result(KIND_TX, '0, '0, rd[8*k +: 8], k == n - 1);
                fstate    = WAIT_SYNC1;
                field_cnt = '0;
            end
            return;
        end
        case (fstate)
            WAIT_SYNC2: begin
                fstate    = (b == SYNC2) ? GET_CMD : WAIT_SYNC1;
                field_cnt = '0;
            end
            GET_CMD: begin
                if (field_cnt == 0) begin
                    cmd_word  = {8'h00, b};
                    field_cnt = 3'd1;
                end else begin
                    cmd_word[15:8] = b;
                    field_cnt      = '0;
                    fstate         = GET_OFS;
                end
            end
            GET_OFS: begin
                if (field_cnt == 0) begin
                    ofs_word  = {8'h00, b};
                    field_cnt = 3'd1;
                end else begin
                    ofs_word[15:8] = b;
                    field_cnt      = '0;
                    pay_word       = '0;
                    // unknown commands drop the frame here
                    fstate = (payload_bytes(cmd_word) != 0) ? GET_PAY : WAIT_SYNC1;
                end
            end
            GET_PAY: begin
                pay_word  = pay_word | (32'(b) << (8 * field_cnt[1:0]));
                field_cnt = field_cnt + 3'd1;
                if (field_cnt >= payload_bytes(cmd_word)) begin
                    field_cnt = '0;
                    target    = bank_of(cmd_word) + {16'h0000, ofs_word};
                    if (is_read_cmd(cmd_word)) begin
                        queue_result(KIND_READ, target, '0, '0, 1'b1);
                        fstate = READ_OUT;
                    end else begin
                        fstate = WAIT_SYNC1;
                        if (cmd_word == CMD_WR16)
                            pay_word = pay_word & 32'h0000_FFFF;
                        if (cmd_word == CMD_WR_D && ofs_word == CAL_OFFSET &&
                            pay_word == CAL_VALUE) begin
                            queue_result(KIND_WRITE, target, pay_word, '0, 1'b0);
                            queue_result(KIND_CAL, '0, '0, '0, 1'b1);
                        end else begin
                            queue_result(KIND_WRITE, target, pay_word, '0, 1'b1);
                        end
                    end
                end
            end
            READ_OUT: ;  // serial bytes are dropped while a read is out
            default: begin
                field_cnt = '0;
                fstate    = (b == SYNC1) ? WAIT_SYNC2 : WAIT_SYNC1;
            end
        endcase
    endfunction

    always @(posedge aclk) begin
        bus_result_t want;
        bus_result_t got;
        if (!aresetn) begin
            base_reg[REG_BANK_A] = BANK_A_RST;
            base_reg[REG_BANK_B] = BANK_B_RST;
            base_reg[REG_BANK_C] = BANK_C_RST;
            base_reg[REG_BANK_D] = BANK_D_RST;
            fstate    = WAIT_SYNC1;
            field_cnt = '0;
            cmd_word  = '0;
            ofs_word  = '0;
            pay_word  = '0;
            outstanding.delete();
        end else begin
            // register port: track writes, check read-back
            if (psel && penable && pready) begin
                if (pwrite)
                    base_reg[paddr[3:2]] = pwdata;
                else if (prdata !== base_reg[paddr[3:2]])
                    flag($sformatf("%0t: register read at %h: expected %h, actual %h",
                                   $time, paddr, base_reg[paddr[3:2]], prdata));
            end

            // result beats against the oldest outstanding prediction
            if (m_tvalid && m_tready) begin
                got.kind  = m_tuser;
                got.addr  = m_tdata[31:0];
                got.wdata = m_tdata[63:32];
                got.txb   = m_tdata[71:64];
                got.last  = m_tlast;
                if (outstanding.size() == 0) begin
                    flag($sformatf("%0t: result beat with none outstanding: %s",
                                   $time, show(got)));
                end else begin
                    want = outstanding.pop_front();
                    if (got !== want)
                        flag($sformatf("%0t: result mismatch: expected %s / actual %s",
                                       $time, show(want), show(got)));
                end
            end

            if (s_tvalid && s_tready)
                parse_rx_beat(s_tuser, s_tdata[7:0], s_tdata[39:8]);
        end
        pending    = outstanding.size();
        fail_count = mismatches;
    end

endmodule

>>> tb/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srab_pkg::*;
    import srab_tb_pkg::*;

    localparam int HOLD_CYCLES = 300;
    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE      = 8;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [3:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // [7:0] rx_byte, [39:8] read_data
    logic        s_tuser  = 1'b0; // [0] cmd
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;         // [31:0] bus_address, [63:32] write_data, [71:64] tx_byte
    logic [1:0]  m_tuser;         // [1:0] kind
    logic        m_tlast;
    int          fail_count;
    int          pending;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_reqs      = 0;
    int holds_taken    = 0;
    int hold_left      = 0;
    int beats_sent     = 0;

    serial_register_access_bridge_unit uut (.*);
    bridge_checker chk (.*);

    always #4 aclk = ~aclk;

    // Receiver: random stalls, plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_reqs != holds_taken) begin
            holds_taken = hold_reqs;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: too long with no beat moving anywhere
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                quiet = 0;
            else
                quiet++;
        end
        $display("FAIL");
        $finish;
    end

    task automatic send_beat(input logic src, input logic [7:0] b, input logic [31:0] rd);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= src;
        s_tdata  <= {rd, b};
        do @(posedge aclk); while (!s_tready);
        beats_sent++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        send_beat(SRC_RX, b, $urandom);
    endtask

    function automatic logic [31:0] random_word();
        case ($urandom_range(5))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    task automatic read_return(input logic [31:0] rd);
        send_beat(SRC_RDATA, 8'($urandom_range(255)), rd);
    endtask

    // Header, command, offset and as many payload bytes as the command takes
    task automatic send_frame(input logic [15:0] c, input logic [15:0] ofs,
                              input logic [31:0] pay);
        int unsigned n;
        n = payload_bytes(c);
        send_byte(SYNC1);
        send_byte(SYNC2);
        send_byte(c[7:0]);
        send_byte(c[15:8]);
        send_byte(ofs[7:0]);
        send_byte(ofs[15:8]);
        for (int k = 0; k < n; k++)
            send_byte(pay[8*k +: 8]);
    endtask

    task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic reg_read(input logic [1:0] idx);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_banks(input logic [31:0] a, input logic [31:0] b,
                                 input logic [31:0] c, input logic [31:0] d);
        reg_write(REG_BANK_A, a);
        reg_write(REG_BANK_B, b);
        reg_write(REG_BANK_C, c);
        reg_write(REG_BANK_D, d);
        reg_read(REG_BANK_A);
        reg_read(REG_BANK_B);
        reg_read(REG_BANK_C);
        reg_read(REG_BANK_D);
    endtask

    // Stop sending, let all predicted results drain, then settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending != 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    // Mostly valid frames with random content, some broken traffic
    task automatic random_frame();
        int unsigned pick;
        logic [15:0] c;
        logic [15:0] ofs;
        logic [31:0] pay;
        logic [7:0]  b;
        pick = $urandom_range(99);
        if (pick < 75) begin
            c = known_cmd($urandom_range(9));
            case ($urandom_range(3))
                0:       ofs = 16'hFFFF;
                1:       ofs = 16'($urandom_range(15));
                default: ofs = 16'($urandom);
            endcase
            pay = random_word();
            if (c == CMD_WR_D && $urandom_range(2) == 0) begin
                ofs = CAL_OFFSET;
                pay = CAL_VALUE;
            end
            send_frame(c, ofs, pay);
            if (is_read_cmd(c)) begin
                // bytes sent while the read is out get dropped
                repeat ($urandom_range(2)) send_byte(8'($urandom_range(255)));
                read_return(random_word());
            end
        end else if (pick < 85) begin
            do c = 16'($urandom); while (payload_bytes(c) != 0);
            send_frame(c, 16'($urandom), '0);
        end else if (pick < 93) begin
            // noise that leaves the parser hunting for a header
            repeat ($urandom_range(3, 1)) begin
                do b = 8'($urandom_range(255)); while (b == SYNC1);
                send_byte(b);
            end
            if ($urandom_range(1) == 0) begin
                send_byte(SYNC1);
                do b = 8'($urandom_range(255)); while (b == SYNC1 || b == SYNC2);
                send_byte(b);
            end
        end else begin
            read_return(random_word());  // no read outstanding
        end
    endtask

    initial begin
        int target;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset bank bases, every command and the corner cases
        read_return(32'hDEAD_BEEF);
        send_byte(SYNC1);
        send_byte(8'h12);
        send_byte(8'hF9);
        send_byte(8'hFF);
        send_frame(CMD_RD16, 16'h0000, 32'h0000_0000);
        send_byte(SYNC1);
        send_byte(SYNC2);
        read_return(32'hFFFF_FFFF);
        send_frame(CMD_WR16, 16'hFFFF, 32'h0000_FFFF);
        send_frame(CMD_RD32_A, 16'h0004, 32'hFFFF_FFFF);
        read_return(32'h0000_0000);
        send_frame(CMD_WR32_A, 16'h0000, 32'hFFFF_FFFF);
        send_frame(CMD_WR_B, 16'h1234, 32'hA5A5_5A5A);
        send_frame(CMD_RD_B, 16'h8000, 32'h0000_0000);
        read_return(32'h1234_5678);
        send_frame(CMD_WR_C, 16'h00FF, 32'h0000_0000);
        send_frame(CMD_RD_C, 16'hFF00, 32'h5A5A_A5A5);
        read_return(32'h89AB_CDEF);
        send_frame(CMD_WR_D, CAL_OFFSET, CAL_VALUE);
        send_frame(CMD_WR_D, CAL_OFFSET, 32'h0000_0002);
        send_frame(CMD_WR_D, 16'h0005, CAL_VALUE);
        send_frame(CMD_RD_D, 16'hFFFF, 32'h0000_0000);
        read_return(32'hC3C3_3C3C);
        send_frame(16'h0003, 16'h0010, '0);
        send_frame(16'hFFFF, 16'hFFFF, '0);
        send_frame(16'h0101, 16'h0000, '0);
        send_frame(CMD_WR32_A, 16'h0008, 32'h0BAD_F00D);
        drain();

        // Random phases, each with its own bank bases and idling mix
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: program_banks('1, '1, '1, '1);
                1: program_banks('0, '0, '0, '0);
                default: program_banks($urandom, $urandom, $urandom, $urandom);
            endcase
            case (ph)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                    hold_reqs++;
                    // two writes during the hold-off fill the output and stall the input
                    send_frame(CMD_WR_B, 16'h0010, 32'h1111_2222);
                    send_frame(CMD_WR_C, 16'h0020, 32'h3333_4444);
                end
                1: begin
                    send_idle_pct  = 49;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 49;
                end
                default: begin
                    send_idle_pct  = 11;
                    recv_stall_pct = 11;
                end
            endcase
            target = beats_sent + 22;
            while (beats_sent < target)
                random_frame();
            drain();
        end

        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> serial_register_access_bridge_unit.f
rtl/core/srab_pkg.sv
rtl/core/srab_cfg_regs.sv
rtl/core/srab_parser.sv
rtl/core/srab_emitter.sv
rtl/core/serial_register_access_bridge_unit.sv
tb/bridge_checker.sv
tb/tb.sv
